### sv/spkv_pkg.sv
// Shared types and constants of the slotted page key/value store.
`timescale 1ns / 1ps
`default_nettype none
package spkv_pkg;

	localparam logic [2:0] CMD_INS_KEY = 3'd0;
	localparam logic [2:0] CMD_INS_VAL = 3'd1;
	localparam logic [2:0] CMD_LKP_KEY = 3'd2;
	localparam logic [2:0] CMD_SPACE   = 3'd3;
	localparam logic [2:0] CMD_INFO    = 3'd4;
	localparam logic [2:0] CMD_RDBYTE  = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_NO_SPACE  = 2'd2;
	localparam logic [1:0] ST_BAD_INDEX = 2'd3;

	localparam int SLOT_BYTES   = 6;
	localparam int HEADER_BYTES = 2;
	localparam logic [5:0] MAX_ELEMS = 6'd63;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] data_byte;
		logic       last;
		logic [5:0] elem_number;
		logic [8:0] byte_address;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [8:0] key_offset;
		logic [8:0] key_length;
		logic [8:0] value_offset;
		logic [8:0] value_length;
		logic [8:0] free_space;
		logic [7:0] read_byte;
		logic [5:0] element_total;
	} rsp_t;

endpackage
`default_nettype wire

### sv/slotted_page_kv_store_unit.sv
// Top level of the slotted page key/value store: page and staging memories plus sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
// - Request channel (in_valid/in_stall/in_data) carries one command per request:
//   insert key byte, insert value byte, lookup key byte, space query, element
//   info or raw page byte read. Every request yields exactly one response on
//   the response channel (out_valid/out_stall/out_data).
// - Key and value bytes that do not end a key or value, space queries and
//   unused commands go straight to the response. A page read reads one page
//   byte; element info makes six page byte reads of the slot record.
// - A commit does one staging read per copied key and value byte, written
//   through the single page write port, then eight slot and count byte
//   writes. A lookup walks the slots: it reads each slot record, then compares
//   the staged key byte by byte for each slot whose key length matches.
// - The page memory is PAGE_BYTES x 8 (PAGE_BYTES a power of two); addresses
//   wrap modulo the page size.
// - After arst_n releases, a clearing pass zeroes the page, one byte per cycle;
//   in_stall stays high until it is done.
// - The response sits in an output register; while out_stall is high it holds
//   and the next finished response waits, stalling further requests.
module slotted_page_kv_store_unit #(
	parameter int PAGE_BYTES = 512
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire spkv_pkg::req_t  in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output spkv_pkg::rsp_t       out_data
);

	localparam int AW = $clog2(PAGE_BYTES);
	localparam int LW = $clog2(PAGE_BYTES + 1);
	localparam int FW = (LW > 9) ? LW : 9;
	localparam int NW = FW + 1;
	localparam logic [LW-1:0] PAGE_LEN = LW'(PAGE_BYTES);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_SLOT  = 4'd2;
	localparam logic [3:0] S_EVAL  = 4'd3;
	localparam logic [3:0] S_CMP   = 4'd4;
	localparam logic [3:0] S_COPY  = 4'd5;
	localparam logic [3:0] S_WSLOT = 4'd6;
	localparam logic [3:0] S_RD    = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	// memories
	logic [7:0] page_mem [PAGE_BYTES];
	logic [7:0] stg_mem  [PAGE_BYTES];
	logic [7:0] page_rdata, stg_rdata;
	logic          page_we, stg_we;
	logic [AW-1:0] page_waddr, page_raddr, stg_waddr, stg_raddr;
	logic [7:0]    page_wdata;

	// control state
	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [5:0]    count_q;
	logic [LW-1:0] lowest_q;
	logic [LW-1:0] sk_q, sv_q;
	logic          info_mode_q;
	logic [5:0]    el_q;
	logic [2:0]    idx_q;
	logic [47:0]   sb_q;
	logic [LW-1:0] lk_len_q;
	logic [LW-1:0] iss_q, got_q;
	logic          cmp_v_s1;
	logic [LW-1:0] cm_pos_q, cm_len_q, cm_k_q, cm_v_q;
	logic          cp_v_s1;
	logic [AW-1:0] cp_waddr_s1;
	logic [2:0]    wcnt_q;
	spkv_pkg::rsp_t res_q;
	logic          out_valid_q;
	spkv_pkg::rsp_t out_q;

	// free space and staging arithmetic
	logic [8:0]    used;
	logic [FW-1:0] lowest_fw, used_fw, free_fw;
	logic [LW-1:0] stg_total, sk_base, v_new, sk_new, pos_new;
	logic          stg_ok, key_ok;
	logic [NW-1:0] need;
	logic          commit_fail;
	logic [8:0]    slot_base, cm_slot;
	logic [15:0]   pos16, ks16, vs16;
	logic          last_el, ks_match;
	logic          accept, out_free;
	logic [1:0]    acc_status;

	assign used      = 9'(spkv_pkg::HEADER_BYTES) + 9'(count_q) * 9'(spkv_pkg::SLOT_BYTES);
	assign lowest_fw = FW'(lowest_q);
	assign used_fw   = FW'(used);
	assign free_fw   = (lowest_fw > used_fw) ? (lowest_fw - used_fw) : '0;

	assign stg_total = sk_q + sv_q;
	assign stg_ok    = stg_total < PAGE_LEN;
	assign v_new     = sv_q + LW'(stg_ok);
	assign sk_base   = (sv_q != '0) ? '0 : sk_q;
	assign key_ok    = sk_base < PAGE_LEN;
	assign sk_new    = sk_base + LW'(key_ok);
	assign need      = NW'(spkv_pkg::SLOT_BYTES) + NW'(sk_q) + NW'(v_new);
	assign commit_fail = (sk_q == '0) || (v_new == '0) || (count_q >= spkv_pkg::MAX_ELEMS)
		|| (need > NW'(free_fw));
	assign pos_new   = lowest_q - sk_q - v_new;

	assign slot_base = 9'(spkv_pkg::HEADER_BYTES) + 9'(el_q) * 9'(spkv_pkg::SLOT_BYTES);
	assign cm_slot   = used;
	assign pos16     = sb_q[15:0];
	assign ks16      = sb_q[31:16];
	assign vs16      = sb_q[47:32];
	assign last_el   = (7'(el_q) + 7'd1) >= 7'(count_q);
	assign ks_match  = ks16 == 16'(lk_len_q);

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign out_free = !out_valid_q || !out_stall;

	// status known right at acceptance
	always_comb begin
		acc_status = spkv_pkg::ST_OK;
		case (in_data.cmd)
			spkv_pkg::CMD_LKP_KEY: begin
				if (in_data.last && (count_q == '0)) begin
					acc_status = spkv_pkg::ST_NOT_FOUND;
				end
			end
			spkv_pkg::CMD_INS_VAL: begin
				if (in_data.last && commit_fail) begin
					acc_status = spkv_pkg::ST_NO_SPACE;
				end
			end
			spkv_pkg::CMD_INFO: begin
				if (in_data.elem_number >= count_q) begin
					acc_status = spkv_pkg::ST_BAD_INDEX;
				end
			end
			default: ;
		endcase
	end

	// page read address
	always_comb begin
		case (state_q)
			S_IDLE:  page_raddr = AW'(in_data.byte_address);
			S_SLOT:  page_raddr = AW'(10'(slot_base) + 10'(idx_q));
			S_CMP:   page_raddr = AW'(pos16 + 16'(iss_q));
			default: page_raddr = '0;
		endcase
	end

	// page write port: clearing, copy, slot record and element count writes
	always_comb begin
		page_we    = 1'b0;
		page_waddr = '0;
		page_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				page_we    = 1'b1;
				page_waddr = clr_q;
			end
			S_COPY: begin
				page_we    = cp_v_s1;
				page_waddr = cp_waddr_s1;
				page_wdata = stg_rdata;
			end
			S_WSLOT: begin
				page_we = 1'b1;
				if (wcnt_q < 3'd6) begin
					page_waddr = AW'(10'(cm_slot) + 10'(wcnt_q));
				end else begin
					page_waddr = AW'(wcnt_q - 3'd6);
				end
				case (wcnt_q)
					3'd0:    page_wdata = 8'(16'(cm_pos_q));
					3'd1:    page_wdata = 8'(16'(cm_pos_q) >> 8);
					3'd2:    page_wdata = 8'(16'(cm_k_q));
					3'd3:    page_wdata = 8'(16'(cm_k_q) >> 8);
					3'd4:    page_wdata = 8'(16'(cm_v_q));
					3'd5:    page_wdata = 8'(16'(cm_v_q) >> 8);
					3'd6:    page_wdata = 8'(count_q + 6'd1);
					default: page_wdata = 8'h00;
				endcase
			end
			default: ;
		endcase
	end

	// staging ports
	always_comb begin
		stg_we    = 1'b0;
		stg_waddr = '0;
		if (accept && (in_data.cmd == spkv_pkg::CMD_INS_VAL)) begin
			stg_we    = stg_ok;
			stg_waddr = AW'(stg_total);
		end else if (accept && ((in_data.cmd == spkv_pkg::CMD_INS_KEY)
			|| (in_data.cmd == spkv_pkg::CMD_LKP_KEY))) begin
			stg_we    = key_ok;
			stg_waddr = AW'(sk_base);
		end
		stg_raddr = AW'(iss_q);
	end

	always_ff @(posedge clk) begin
		if (page_we) begin
			page_mem[page_waddr] <= page_wdata;
		end
		page_rdata <= page_mem[page_raddr];
	end

	always_ff @(posedge clk) begin
		if (stg_we) begin
			stg_mem[stg_waddr] <= in_data.data_byte;
		end
		stg_rdata <= stg_mem[stg_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			lowest_q    <= PAGE_LEN;
			sk_q        <= '0;
			sv_q        <= '0;
			info_mode_q <= 1'b0;
			el_q        <= '0;
			idx_q       <= '0;
			iss_q       <= '0;
			got_q       <= '0;
			cmp_v_s1    <= 1'b0;
			cp_v_s1     <= 1'b0;
			wcnt_q      <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(PAGE_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						res_q <= '{status: acc_status, default: '0};
						case (in_data.cmd) inside
							spkv_pkg::CMD_INS_KEY, spkv_pkg::CMD_LKP_KEY: begin
								sv_q <= '0;
								if ((in_data.cmd == spkv_pkg::CMD_LKP_KEY) && in_data.last) begin
									sk_q        <= '0;
									lk_len_q    <= sk_new;
									info_mode_q <= 1'b0;
									el_q        <= '0;
									idx_q       <= '0;
									if (count_q == '0) begin
										state_q <= S_DONE;
									end else begin
										state_q <= S_SLOT;
									end
								end else begin
									sk_q    <= sk_new;
									state_q <= S_DONE;
								end
							end
							spkv_pkg::CMD_INS_VAL: begin
								if (in_data.last) begin
									sk_q <= '0;
									sv_q <= '0;
									if (commit_fail) begin
										state_q <= S_DONE;
									end else begin
										cm_pos_q <= pos_new;
										cm_k_q   <= sk_q;
										cm_v_q   <= v_new;
										cm_len_q <= sk_q + v_new;
										iss_q    <= '0;
										cp_v_s1  <= 1'b0;
										state_q  <= S_COPY;
									end
								end else begin
									sv_q    <= v_new;
									state_q <= S_DONE;
								end
							end
							spkv_pkg::CMD_INFO: begin
								if (in_data.elem_number >= count_q) begin
									state_q <= S_DONE;
								end else begin
									info_mode_q <= 1'b1;
									el_q        <= in_data.elem_number;
									idx_q       <= '0;
									state_q     <= S_SLOT;
								end
							end
							spkv_pkg::CMD_RDBYTE: state_q <= S_RD;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SLOT: begin
					// gather the six record bytes, one read per cycle
					if (idx_q != 3'd0) begin
						sb_q <= {page_rdata, sb_q[47:8]};
					end
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd6) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (info_mode_q) begin
						res_q <= '{key_offset: pos16[8:0], key_length: ks16[8:0],
							value_offset: 9'(pos16 + ks16), value_length: vs16[8:0],
							default: '0};
						state_q <= S_DONE;
					end else if (ks_match) begin
						iss_q    <= '0;
						got_q    <= '0;
						cmp_v_s1 <= 1'b0;
						state_q  <= S_CMP;
					end else if (last_el) begin
						res_q.status <= spkv_pkg::ST_NOT_FOUND;
						state_q      <= S_DONE;
					end else begin
						el_q    <= el_q + 6'd1;
						idx_q   <= '0;
						state_q <= S_SLOT;
					end
				end
				S_CMP: begin
					if (got_q == lk_len_q) begin
						res_q <= '{value_offset: 9'(pos16 + ks16), value_length: vs16[8:0],
							default: '0};
						cmp_v_s1 <= 1'b0;
						state_q  <= S_DONE;
					end else if (cmp_v_s1 && (page_rdata != stg_rdata)) begin
						// drop this slot, advance to the next one
						cmp_v_s1 <= 1'b0;
						if (last_el) begin
							res_q.status <= spkv_pkg::ST_NOT_FOUND;
							state_q      <= S_DONE;
						end else begin
							el_q    <= el_q + 6'd1;
							idx_q   <= '0;
							state_q <= S_SLOT;
						end
					end else begin
						cmp_v_s1 <= iss_q < lk_len_q;
						if (iss_q < lk_len_q) begin
							iss_q <= iss_q + 1'b1;
						end
						if (cmp_v_s1) begin
							got_q <= got_q + 1'b1;
						end
					end
				end
				S_COPY: begin
					cp_v_s1     <= iss_q < cm_len_q;
					cp_waddr_s1 <= AW'(cm_pos_q + iss_q);
					if (iss_q < cm_len_q) begin
						iss_q <= iss_q + 1'b1;
					end else if (!cp_v_s1) begin
						wcnt_q  <= '0;
						state_q <= S_WSLOT;
					end
				end
				S_WSLOT: begin
					wcnt_q <= wcnt_q + 3'd1;
					if (wcnt_q == 3'd7) begin
						count_q  <= count_q + 6'd1;
						lowest_q <= cm_pos_q;
						state_q  <= S_DONE;
					end
				end
				S_RD: begin
					res_q.read_byte <= page_rdata;
					state_q         <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// response valid: raise on completion, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			out_q <= '{status: res_q.status, key_offset: res_q.key_offset,
				key_length: res_q.key_length, value_offset: res_q.value_offset,
				value_length: res_q.value_length, free_space: free_fw[8:0],
				read_byte: res_q.read_byte, element_total: count_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_space_never_negative: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |-> (lowest_fw >= used_fw))
		else $error("slot table overlaps data area");

	a_commit_bumps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WSLOT && wcnt_q == 3'd7) |=> (count_q == $past(count_q) + 6'd1))
		else $error("commit did not advance element count");

	a_response_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised outside completion");
`endif

endmodule
`default_nettype wire
